@@ rtl/ikc_pkg.sv @@
// ----------------------------------------------------------------------------
// ikc_pkg
// Shared types and codes for the image kernel convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package ikc_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_PIXEL    = 2'd1;
   localparam logic [1:0] CMD_FLUSH    = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // sequencer to multiply-accumulate unit
   typedef struct packed {
      logic start;   // clear accumulator
      logic tap;     // a read was issued this cycle
      logic last;    // that read is the final tap
   } mac_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/ikc_coef_ram.sv @@
// ----------------------------------------------------------------------------
// ikc_coef_ram
// Kernel coefficient memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ikc_coef_ram #(
   parameter int DEPTH = 225,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [15:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/ikc_line_ram.sv @@
// ----------------------------------------------------------------------------
// ikc_line_ram
// Pixel ring memory holding the rows the kernel window spans.
// ----------------------------------------------------------------------------
`default_nettype none

module ikc_line_ram #(
   parameter int DEPTH = 7680,
   parameter int AW    = 13
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/ikc_mac.sv @@
// ----------------------------------------------------------------------------
// ikc_mac
// Shared multiply-accumulate with output clamp to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module ikc_mac
   import ikc_pkg::*;
#(
   parameter int ACC_W     = 33,
   parameter int FRAC_BITS = 12
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mac_ctrl_type ctrl,
   input  wire logic [7:0]   pix,
   input  wire logic [15:0]  coef,
   output logic              done,
   output logic [7:0]        result
);

   logic               tap_d1_ff, last_d1_ff;
   logic               tap_d2_ff, last_d2_ff;
   logic               done_ff;
   logic signed [24:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]   shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_d1_ff  <= 1'b0;
         last_d1_ff <= 1'b0;
         tap_d2_ff  <= 1'b0;
         last_d2_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         tap_d1_ff  <= ctrl.tap;
         last_d1_ff <= ctrl.tap & ctrl.last;
         tap_d2_ff  <= tap_d1_ff;
         last_d2_ff <= last_d1_ff;
         done_ff    <= last_d2_ff;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.start) begin
         acc_in = '0;
      end else if (tap_d2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, pix}) * $signed(coef);
      acc_ff  <= acc_in;
   end

   assign shifted = ACC_W'(acc_ff) >> FRAC_BITS;
   assign done    = done_ff;

   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         result = 8'd0;
      end else if (|shifted[ACC_W-1:8]) begin
         result = 8'd255;
      end else begin
         result = shifted[7:0];
      end
   end

endmodule

`default_nettype wire

@@ rtl/image_kernel_convolution.sv @@
// ----------------------------------------------------------------------------
// image_kernel_convolution
// 2D convolution of a raster grayscale frame, replicate borders.
// ----------------------------------------------------------------------------
// Filters a raster-order 8-bit frame with a square (2r+1)x(2r+1) kernel of
// signed Q4.12 coefficients, replicating edge pixels. Items carry a kind on
// req_tuser: load a coefficient, push a pixel, or a flush step. Once r rows
// plus r pixels are buffered each pixel transaction yields one output pixel;
// flush transactions drain the tail after the last pixel. Frame end is
// marked with rsp_tlast. Loads and transactions that produce nothing leave
// the block idle. For a transaction that produces a pixel, the single
// multiply-accumulate unit walks every tap, reading one pixel from the line
// ring memory and one coefficient from the coefficient memory per cycle.
// A finished pixel waits in the output register while the next transaction
// is accepted. Any geometry register write restarts the frame; register
// values are saturated to their legal ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module image_kernel_convolution
   import ikc_pkg::*;
#(
   parameter int MAX_WIDTH      = 512,
   parameter int MAX_HEIGHT     = 512,
   parameter int MAX_KERNEL     = 15,
   parameter int COEF_FRAC_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // coef_index[7:0], coef_value[23:8], pixel_in[31:24]
   input  wire logic [1:0]  req_tuser,  // cmd[1:0]
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // pixel_out[7:0]
   output logic             rsp_tlast,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int MAX_RADIUS = (MAX_KERNEL - 1) / 2;
   localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int CW   = $clog2(COEF_DEPTH);
   localparam int LA   = $clog2(LINE_DEPTH);
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int KW   = $clog2(MAX_KERNEL);
   localparam int XS   = XW + 2;
   localparam int YS   = YW + 2;
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int ACC_W = 25 + $clog2(COEF_DEPTH);

   // ---------------- registers ----------------
   logic [9:0] width_ff,  width_in;
   logic [9:0] height_ff, height_in;
   logic [2:0] radius_ff, radius_in;
   logic       csr_wr;
   logic [1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_WIDTH:  width_in  = csr_pwdata[9:0];
            REG_HEIGHT: height_in = csr_pwdata[9:0];
            REG_RADIUS: radius_in = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WIDTH:  csr_prdata = {22'd0, width_ff};
         REG_HEIGHT: csr_prdata = {22'd0, height_ff};
         REG_RADIUS: csr_prdata = {29'd0, radius_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd320;
         height_ff <= 10'd240;
         radius_ff <= 3'd1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
      end
   end

   // Saturated geometry.
   logic [WW-1:0]  w_eff;
   logic [HW-1:0]  h_eff;
   logic [RW-1:0]  r_eff;
   logic [KW:0]    k_size;
   logic [CNT_W-1:0] total, delay;

   always_comb begin
      if (width_ff == 10'd0)                    w_eff = WW'(1);
      else if (32'(width_ff) > MAX_WIDTH)       w_eff = WW'(MAX_WIDTH);
      else                                      w_eff = WW'(width_ff);
      if (height_ff == 10'd0)                   h_eff = HW'(1);
      else if (32'(height_ff) > MAX_HEIGHT)     h_eff = HW'(MAX_HEIGHT);
      else                                      h_eff = HW'(height_ff);
      if (radius_ff == 3'd0)                    r_eff = RW'(1);
      else if (32'(radius_ff) > MAX_RADIUS)     r_eff = RW'(MAX_RADIUS);
      else                                      r_eff = RW'(radius_ff);
   end

   assign k_size = (KW + 1)'({r_eff, 1'b1});
   assign total  = CNT_W'(w_eff * h_eff);
   assign delay  = CNT_W'(r_eff * w_eff) + CNT_W'(r_eff);

   // ---------------- frame state ----------------
   state_type state_ff, state_in;

   logic [CNT_W-1:0] in_cnt_ff, in_cnt_in;
   logic [CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [LA-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [XW-1:0]    x_ff, x_in;
   logic [YW-1:0]    y_ff, y_in;
   logic [LA-1:0]    top_base_ff, top_base_in;

   // tap walk
   logic [KW-1:0]        kx_ff, kx_in, ky_ff, ky_in;
   logic signed [XS-1:0] px_ff, px_in;
   logic signed [YS-1:0] py_ff, py_in;
   logic [LA-1:0]        rb_ff, rb_in;
   logic [CW-1:0]        ci_ff, ci_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;

   logic [1:0]  cmd;
   logic        accept, is_pixel, do_store, want_emit, last_tap, load_rsp;
   logic [CNT_W-1:0] in_next;
   logic [CNT_W:0]   out_plus_d;
   logic signed [XS-1:0] x_start, w_m1_s;
   logic signed [YS-1:0] y_start, h_m1_s;
   logic [XW-1:0]        px_clamp;
   logic [LA:0]          rd_sum, rb_step, top_step;
   logic [LA-1:0]        rd_addr;
   logic [7:0]           line_q;
   logic [15:0]          coef_q;
   logic                 mac_done;
   logic [7:0]           mac_result;
   mac_ctrl_type         mac_ctrl;

   assign cmd      = req_tuser;
   assign accept   = req_tvalid & req_tready;
   assign is_pixel = (cmd == CMD_PIXEL);
   assign do_store = accept & is_pixel & (in_cnt_ff < total);
   assign in_next  = do_store ? in_cnt_ff + CNT_W'(1) : in_cnt_ff;
   assign out_plus_d = (CNT_W + 1)'(out_cnt_ff) + (CNT_W + 1)'(delay);
   assign want_emit = accept & (is_pixel | (cmd == CMD_FLUSH)) & (out_cnt_ff < total)
                      & ((in_next >= total) | ((CNT_W + 1)'(in_next) > out_plus_d));

   assign x_start = $signed(XS'(x_ff)) - $signed(XS'(r_eff));
   assign y_start = $signed(YS'(y_ff)) - $signed(YS'(r_eff));
   assign w_m1_s  = $signed(XS'(w_eff - WW'(1)));
   assign h_m1_s  = $signed(YS'(h_eff - HW'(1)));

   assign last_tap = ((KW + 1)'(kx_ff) == k_size - (KW + 1)'(1))
                   & ((KW + 1)'(ky_ff) == k_size - (KW + 1)'(1));
   assign load_rsp = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp_tready);

   // Replicate the border column.
   always_comb begin
      if (px_ff < 0)           px_clamp = '0;
      else if (px_ff > w_m1_s) px_clamp = XW'(w_m1_s);
      else                     px_clamp = XW'(px_ff);
   end

   // Ring address: row base plus column, wrapped once.
   assign rd_sum   = (LA + 1)'(rb_ff) + (LA + 1)'(px_clamp);
   assign rd_addr  = (rd_sum >= (LA + 1)'(LINE_DEPTH)) ?
                     LA'(rd_sum - (LA + 1)'(LINE_DEPTH)) : LA'(rd_sum);
   assign rb_step  = (LA + 1)'(rb_ff) + (LA + 1)'(w_eff);
   assign top_step = (LA + 1)'(top_base_ff) + (LA + 1)'(w_eff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (want_emit) state_in = ST_ISSUE;
         ST_ISSUE: if (last_tap)  state_in = ST_DRAIN;
         ST_DRAIN: if (mac_done)  state_in = ST_EMIT;
         ST_EMIT:  if (load_rsp)  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      mac_ctrl     = '{start: 1'b0, tap: 1'b0, last: 1'b0};
      in_cnt_in    = in_next;
      wr_ptr_in    = wr_ptr_ff;
      out_cnt_in   = out_cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      top_base_in  = top_base_ff;
      kx_in        = kx_ff;
      ky_in        = ky_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rb_in        = rb_ff;
      ci_in        = ci_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      if (do_store) begin
         wr_ptr_in = (32'(wr_ptr_ff) == LINE_DEPTH - 1) ? '0 : wr_ptr_ff + LA'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            // start the tap walk at the window's top-left corner
            kx_in = '0;
            ky_in = '0;
            px_in = x_start;
            py_in = y_start;
            rb_in = top_base_ff;
            ci_in = '0;
            mac_ctrl.start = want_emit;
         end
         ST_ISSUE: begin
            mac_ctrl.tap  = 1'b1;
            mac_ctrl.last = last_tap;
            ci_in = ci_ff + CW'(1);
            if ((KW + 1)'(kx_ff) == k_size - (KW + 1)'(1)) begin
               kx_in = '0;
               px_in = x_start;
               ky_in = ky_ff + KW'(1);
               py_in = py_ff + YS'(1);
               // advance the row base only while the current and next rows are inside the frame
               if (py_ff >= 0 && py_ff < h_m1_s) begin
                  rb_in = (rb_step >= (LA + 1)'(LINE_DEPTH)) ?
                          LA'(rb_step - (LA + 1)'(LINE_DEPTH)) : LA'(rb_step);
               end
            end else begin
               kx_in = kx_ff + KW'(1);
               px_in = px_ff + XS'(1);
            end
         end
         ST_DRAIN: ;
         ST_EMIT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               if (out_cnt_ff + CNT_W'(1) == total) begin
                  out_cnt_in  = '0;
                  in_cnt_in   = '0;
                  wr_ptr_in   = '0;
                  x_in        = '0;
                  y_in        = '0;
                  top_base_in = '0;
               end else begin
                  out_cnt_in = out_cnt_ff + CNT_W'(1);
                  if (WW'(x_ff) == w_eff - WW'(1)) begin
                     x_in = '0;
                     y_in = y_ff + YW'(1);
                     // top window row moves once the window clears row zero
                     if ((YW + 1)'(y_ff) + (YW + 1)'(1) > (YW + 1)'(r_eff)) begin
                        top_base_in = (top_step >= (LA + 1)'(LINE_DEPTH)) ?
                                      LA'(top_step - (LA + 1)'(LINE_DEPTH)) :
                                      LA'(top_step);
                     end
                  end else begin
                     x_in = x_ff + XW'(1);
                  end
               end
            end
         end
         default: ;
      endcase

      // geometry write restarts the frame
      if (csr_wr && (csr_idx == REG_WIDTH || csr_idx == REG_HEIGHT
                     || csr_idx == REG_RADIUS)) begin
         out_cnt_in  = '0;
         in_cnt_in   = '0;
         wr_ptr_in   = '0;
         x_in        = '0;
         y_in        = '0;
         top_base_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         wr_ptr_ff    <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         top_base_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         wr_ptr_ff    <= wr_ptr_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         top_base_ff  <= top_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk counters and result payload need no reset.
   always_ff @(posedge clock) begin
      kx_ff <= kx_in;
      ky_ff <= ky_in;
      px_ff <= px_in;
      py_ff <= py_in;
      rb_ff <= rb_in;
      ci_ff <= ci_in;
      if (load_rsp) begin
         rsp_data_ff <= mac_result;
         rsp_last_ff <= (out_cnt_ff + CNT_W'(1) == total);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- memories and arithmetic ----------------
   logic coef_wr;
   assign coef_wr = accept & (cmd == CMD_LOAD) & (32'(req_tdata[7:0]) < COEF_DEPTH);

   ikc_coef_ram #(
      .DEPTH (COEF_DEPTH),
      .AW    (CW)
   ) u_coef (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (CW'(req_tdata[7:0])),
      .wr_data (req_tdata[23:8]),
      .rd_en   (mac_ctrl.tap),
      .rd_addr (ci_ff),
      .rd_data (coef_q)
   );

   ikc_line_ram #(
      .DEPTH (LINE_DEPTH),
      .AW    (LA)
   ) u_line (
      .clock   (clock),
      .wr_en   (do_store),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_tdata[31:24]),
      .rd_en   (mac_ctrl.tap),
      .rd_addr (rd_addr),
      .rd_data (line_q)
   );

   ikc_mac #(
      .ACC_W     (ACC_W),
      .FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .pix    (line_q),
      .coef   (coef_q),
      .done   (mac_done),
      .result (mac_result)
   );

endmodule

`default_nettype wire

@@ verif/tb_image_kernel_convolution.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_image_kernel_convolution
// Self-checking stream testbench for the image kernel convolution block.
// ----------------------------------------------------------------------------
// A queue of pending transactions feeds a clocked driver. A clocked monitor
// checks each result against a convolution predictor in the bench, which runs
// on every accepted transaction. Phases cover a directed opening, geometry
// extremes and saturated register values, then random small frames with
// random kernels, noise, aborted frames and random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_image_kernel_convolution;
   import ikc_pkg::*;

   localparam int MAX_W      = 512;
   localparam int MAX_H      = 512;
   localparam int MAX_R      = 7;
   localparam int COEF_DEPTH = 225;
   localparam int LINE_DEPTH = 15 * MAX_W;
   localparam int FRAC_BITS  = 12;
   localparam int SETTLE     = 240;   // longest busy stretch of one transaction
   localparam int STALL_MAX  = 4000;  // cycles without any acceptance

   typedef struct {
      logic [1:0]         cmd;
      logic [7:0]         coef_index;
      logic signed [15:0] coef_value;
      logic [7:0]         pixel;
   } job_type;

   typedef struct {
      logic [7:0] pixel;
      logic       last;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // coef_index[7:0], coef_value[23:8], pixel_in[31:24]
   logic [1:0]  req_tuser = '0;  // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // pixel_out[7:0]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   image_kernel_convolution i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: its own copy of the geometry, kernel and pixel ring
   // ------------------------------------------------------------------------
   logic [9:0]  geom_width  = 10'd320;
   logic [9:0]  geom_height = 10'd240;
   logic [2:0]  geom_radius = 3'd1;
   logic [15:0] kernel_mem [COEF_DEPTH];
   logic [7:0]  ring_mem   [LINE_DEPTH];
   int          pixels_in;
   int          pixels_out;

   job_type     pending_jobs[$];
   result_type  expected_pixels[$];
   job_type     cur_job;
   int          fail_count;
   int          csr_fired;
   bit          calm;    // no idling on either side while set

   function automatic int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Advance the predictor by one accepted transaction; queue any pixel it owes.
   task automatic convolve_step(job_type j);
      int         w, h, r, total, delay, side, y, x, py, px;
      longint     acc;
      result_type res;
      w     = clip(geom_width, 1, MAX_W);
      h     = clip(geom_height, 1, MAX_H);
      r     = clip(geom_radius, 1, MAX_R);
      side  = 2 * r + 1;
      total = w * h;
      delay = r * w + r;
      if (j.cmd == CMD_LOAD) begin
         if (j.coef_index < COEF_DEPTH) kernel_mem[j.coef_index] = j.coef_value;
         return;
      end
      if (j.cmd != CMD_PIXEL && j.cmd != CMD_FLUSH) return;
      if (j.cmd == CMD_PIXEL && pixels_in < total) begin
         ring_mem[pixels_in % LINE_DEPTH] = j.pixel;
         pixels_in++;
      end
      if (pixels_out < total && (pixels_in >= total || pixels_in > pixels_out + delay)) begin
         y   = pixels_out / w;
         x   = pixels_out % w;
         acc = 0;
         for (int ky = 0; ky < side; ky++) begin
            py = clip(y + ky - r, 0, h - 1);
            for (int kx = 0; kx < side; kx++) begin
               px  = clip(x + kx - r, 0, w - 1);
               acc += longint'(ring_mem[(py * w + px) % LINE_DEPTH])
                      * longint'($signed(kernel_mem[ky * side + kx]));
            end
         end
         if (acc < 0) res.pixel = 8'd0;
         else if ((acc >>> FRAC_BITS) > 255) res.pixel = 8'd255;
         else res.pixel = acc[FRAC_BITS +: 8];
         res.last = (pixels_out + 1 == total);
         expected_pixels = {expected_pixels, res};
         pixels_out++;
         if (pixels_out >= total) begin
            pixels_out = 0;
            pixels_in  = 0;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: one transaction per handshake, random gap drawn per item
   // ------------------------------------------------------------------------
   bit req_fired;
   int req_gap;

   always @(posedge clock) begin
      req_fired = !reset && req_tvalid && req_tready;
      if (req_fired) convolve_step(cur_job);
   end

   always @(negedge clock) begin
      bit next_valid;
      next_valid = req_tvalid && !req_fired;
      if (!next_valid && !reset) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_jobs.size() > 0) begin
            cur_job    = pending_jobs.pop_front();
            req_tdata  <= {cur_job.pixel, cur_job.coef_value, cur_job.coef_index};
            req_tuser  <= cur_job.cmd;
            next_valid = 1'b1;
            req_gap    = calm ? 0 : $urandom_range(0, 7);
         end
      end
      req_tvalid <= next_valid;
   end

   // ------------------------------------------------------------------------
   // Monitor: random backpressure, compare against the oldest expectation
   // ------------------------------------------------------------------------
   bit rsp_fired;
   int rsp_wait;

   always @(posedge clock) begin
      result_type want;
      rsp_fired = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fired) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: pixel_out %0d frame_end %0d", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata !== want.pixel) begin
               $error("pixel_out: expected %0d, actual %0d", want.pixel, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("frame_end: expected %0d, actual %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_fired) rsp_wait = calm ? 0 : $urandom_range(0, 7);
      if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: stop the run when nothing moves for too long
   // ------------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || req_fired || rsp_fired || csr_fired > 0) begin
         quiet_cycles = 0;
         csr_fired    = 0;
      end else if (++quiet_cycles >= STALL_MAX) begin
         $error("watchdog: no transaction for %0d cycles", STALL_MAX);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   function automatic job_type make_job(logic [1:0] cmd);
      job_type j;
      j.cmd        = cmd;
      j.coef_index = 8'($urandom_range(0, 255));
      j.coef_value = 16'($urandom_range(0, 65535));
      j.pixel      = 8'($urandom_range(0, 255));
      return j;
   endfunction

   task automatic enqueue_job(job_type j);
      pending_jobs = {pending_jobs, j};
   endtask

   task automatic push_load(int idx, logic [15:0] value);
      job_type j;
      j            = make_job(CMD_LOAD);
      j.coef_index = 8'(idx);
      j.coef_value = value;
      enqueue_job(j);
   endtask

   // Hold until every queued transaction is accepted and every result is back.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_jobs.size() > 0 || req_tvalid || expected_pixels.size() > 0);
      @(negedge clock);
   endtask

   // Setup and access cycle, then the bus goes idle.
   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_fired = 1;
      case (index)
         REG_WIDTH:  geom_width  = value[9:0];
         REG_HEIGHT: geom_height = value[9:0];
         REG_RADIUS: geom_radius = value[2:0];
         default: ;
      endcase
      pixels_in  = 0;
      pixels_out = 0;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // One frame: settle, program geometry, load the kernel, stream the pixels,
   // then drain the tail with flushes (some of them surplus pixels).
   task automatic run_frame(int w_raw, int h_raw, int r_raw, output int sent);
      int      r, side, total, cut, owed, style;
      job_type j;
      sent = 0;
      wait_idle();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      calm = ($urandom_range(0, 3) == 0);
      csr_write(REG_WIDTH,  {22'($urandom_range(0, 4194303)), 10'(w_raw)});
      csr_write(REG_HEIGHT, {22'($urandom_range(0, 4194303)), 10'(h_raw)});
      csr_write(REG_RADIUS, {29'($urandom_range(0, 536870911)), 3'(r_raw)});
      r     = clip(r_raw, 1, MAX_R);
      side  = 2 * r + 1;
      total = clip(w_raw, 1, MAX_W) * clip(h_raw, 1, MAX_H);
      style = $urandom_range(0, 3);
      for (int k = 0; k < side * side; k++) begin
         case (style)
            0:       push_load(k, k == side * side / 2 ? 16'd4096 : 16'd0);
            1:       push_load(k, 16'($urandom_range(0, 1536) - 512));
            2:       push_load(k, 16'($urandom_range(0, 8192) - 4096));
            default: push_load(k, 16'($urandom_range(0, 65535)));
         endcase
      end
      sent += side * side;
      // Abort some frames part way; the next geometry write restarts them.
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total) : total;
      for (int p = 0; p < cut; p++) begin
         case ($urandom_range(0, 31))
            0: enqueue_job(make_job(CMD_RESERVED));
            1: begin
               enqueue_job(make_job(CMD_FLUSH));
               sent++;
            end
            2: begin
               push_load($urandom_range(0, side * side - 1), 16'($urandom_range(0, 4096)));
               sent++;
            end
            default: ;
         endcase
         enqueue_job(make_job(CMD_PIXEL));
         sent++;
      end
      if (cut < total) return;
      wait_idle();
      owed = (pixels_in == total) ? total - pixels_out : 0;
      for (int f = 0; f < owed; f++) begin
         j = make_job($urandom_range(0, 3) == 0 ? CMD_PIXEL : CMD_FLUSH);
         enqueue_job(j);
      end
      sent += owed;
   endtask

   initial begin
      int sent, items_sent, random_frames;
      for (int k = 0; k < COEF_DEPTH; k++) kernel_mem[k] = '0;
      for (int k = 0; k < LINE_DEPTH; k++) ring_mem[k] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening under the reset geometry: coefficient extremes,
      // out-of-range load indexes, the unknown command and an early flush.
      push_load(0, 16'h8000);
      push_load(1, 16'h7FFF);
      push_load(2, 16'hFFFF);
      push_load(3, 16'h0000);
      push_load(4, 16'h1000);
      push_load(5, 16'h5555);
      push_load(6, 16'hAAAA);
      push_load(7, 16'h0001);
      push_load(8, 16'hF000);
      push_load(225, 16'h1234);
      push_load(255, 16'hFFFF);
      enqueue_job(make_job(CMD_RESERVED));
      enqueue_job(make_job(CMD_FLUSH));
      cur_job       = make_job(CMD_PIXEL);
      cur_job.pixel = 8'd0;
      enqueue_job(cur_job);
      cur_job.pixel = 8'd255;
      enqueue_job(cur_job);
      enqueue_job(make_job(CMD_FLUSH));
      items_sent = pending_jobs.size();

      // Geometry extremes, including saturated register values.
      run_frame(1, 1, 1, sent);
      items_sent += sent;
      run_frame(0, 0, 0, sent);
      items_sent += sent;
      run_frame(3, 2, 7, sent);
      items_sent += sent;
      run_frame(1023, 1, 1, sent);
      items_sent += sent;
      run_frame(1, 1023, 1, sent);
      items_sent += sent;

      // Random small frames.
      random_frames = 0;
      while (items_sent < 1900 || random_frames < 2) begin
         run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7), sent);
         items_sent += sent;
         random_frames++;
      end

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (expected_pixels.size() > 0) begin
         $error("%0d expected results never arrived", expected_pixels.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/ikc_pkg.sv
rtl/ikc_coef_ram.sv
rtl/ikc_line_ram.sv
rtl/ikc_mac.sv
rtl/image_kernel_convolution.sv
verif/tb_image_kernel_convolution.sv
